// ===== rtl/ipcf_pkg.sv =====
`default_nettype none

package ipcf_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int PIXEL_BITS_DEFAULT = 16;

   localparam int PIXEL_FIELD_W = 16;
   localparam int WIDTH_REG_W   = 11;
   localparam int HEIGHT_REG_W  = 16;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // register select is csr_paddr[2]
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/ipcf_ram.sv =====
`default_nettype none

module ipcf_ram #(
   parameter int WIDTH = ipcf_pkg::PIXEL_BITS_DEFAULT,
   parameter int DEPTH = ipcf_pkg::MAX_WIDTH_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read-first: a read of the address being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/isolated_peak_clip_filter.sv =====
`default_nettype none

// Four-neighbour isolated peak clipping filter. Pixels enter in raster order on the req
// stream (tuser low) and leave on the rsp stream with every pixel that is strictly above
// all of its existing up, down, left and right neighbours replaced by the largest of them.
// Results lag one row: the pixel at row r, column c of the input yields filtered pixel
// (r-1, c), the first row yields nothing, and once image_height rows are in, one drain
// transaction (tuser high) per pixel flushes the last row; pixels sent while draining and
// drains sent before it are dropped. rsp tlast marks the last pixel of a row and rsp tuser
// the last pixel of the frame. One transaction is taken every clock unless rsp stalls.
// Line stores: two single-port-read RAMs of MAX_WIDTH words, one per row parity, both
// read per transaction, the row's own written per pixel; results pass s1 and rsp regs.
// Change image_width and image_height only between frames.
module isolated_peak_clip_filter #(
   parameter int MAX_WIDTH  = ipcf_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = ipcf_pkg::PIXEL_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [ipcf_pkg::PIXEL_FIELD_W-1:0]  req_tdata,  // pixel_in
   input  wire logic                                req_tuser,  // mode
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [ipcf_pkg::PIXEL_FIELD_W-1:0]  rsp_tdata,  // pixel_out
   output logic                                     rsp_tlast,  // row_end
   output logic                                     rsp_tuser,  // frame_end
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [ipcf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ipcf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [ipcf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);

   import ipcf_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_STORE  = 2'd1;
   localparam logic [1:0] KIND_FILTER = 2'd2;
   localparam logic [1:0] KIND_DRAIN  = 2'd3;

   // configuration
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic                    csr_write;

   // counters
   logic [AW-1:0]           col_ff;
   logic [HEIGHT_REG_W-1:0] row_ff;
   logic [AW-1:0]           drain_ff;

   // input side decode
   logic [WW-1:0]           w_eff;
   logic [HEIGHT_REG_W-1:0] h_eff;
   logic                    draining;
   logic                    is_drain;
   logic [AW-1:0]           c_sel;
   logic [AW-1:0]           c_next;
   logic [WW-1:0]           c_plus;
   logic                    last;
   logic [1:0]              kind;
   logic                    accept;
   logic                    store_px;
   logic [PIXEL_BITS-1:0]   px_in;

   // line stores
   logic                    wr_even;
   logic                    wr_odd;
   logic [AW-1:0]           rd_addr_even;
   logic [AW-1:0]           rd_addr_odd;
   logic [PIXEL_BITS-1:0]   rd_even;
   logic [PIXEL_BITS-1:0]   rd_odd;

   // working stage
   logic                    s1_valid_ff;
   logic [1:0]              s1_kind_ff;
   logic                    s1_par_ff;
   logic                    s1_first_ff;
   logic                    s1_has_up_ff;
   logic                    s1_has_right_ff;
   logic                    s1_last_ff;
   logic [PIXEL_BITS-1:0]   s1_px_ff;
   logic [PIXEL_BITS-1:0]   first_px_ff;
   logic [PIXEL_BITS-1:0]   win_left_ff;
   logic [PIXEL_BITS-1:0]   win_cur_ff;
   logic                    s1_out;
   logic                    s1_adv;
   logic                    out_free;
   logic [PIXEL_BITS-1:0]   cur;
   logic [PIXEL_BITS-1:0]   up;
   logic [PIXEL_BITS-1:0]   right;
   logic [PIXEL_BITS-1:0]   best;
   logic                    any;
   logic                    peak;
   logic [PIXEL_BITS-1:0]   filtered;

   // result register
   logic                     rsp_valid_ff;
   logic [PIXEL_FIELD_W-1:0] rsp_pixel_ff;
   logic                     rsp_last_ff;
   logic                     rsp_frame_ff;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_IMAGE_WIDTH) begin
            width_ff <= csr_pwdata[WIDTH_REG_W-1:0];
         end else begin
            height_ff <= csr_pwdata[HEIGHT_REG_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_IMAGE_HEIGHT) ? CSR_DATA_W'(height_ff)
                                                          : CSR_DATA_W'(width_ff);

   // ---------------------------------------------------------------- input decode
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
   end

   assign h_eff    = (height_ff == '0) ? HEIGHT_REG_W'(1) : height_ff;
   assign draining = row_ff >= h_eff;
   assign is_drain = req_tuser == MODE_DRAIN;
   assign c_sel    = is_drain ? drain_ff : col_ff;
   assign c_plus   = WW'(c_sel) + WW'(1);
   assign last     = c_plus >= w_eff;
   assign c_next   = (c_sel == AW'(MAX_WIDTH - 1)) ? '0 : c_sel + AW'(1);
   assign px_in    = PIXEL_BITS'(req_tdata);

   always_comb begin
      if (is_drain) begin
         kind = draining ? KIND_DRAIN : KIND_NONE;
      end else if (draining) begin
         kind = KIND_NONE;
      end else begin
         kind = (row_ff != '0) ? KIND_FILTER : KIND_STORE;
      end
   end

   assign accept   = req_tvalid && req_tready;
   assign store_px = accept && (kind == KIND_STORE || kind == KIND_FILTER);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= '0;
      end else if (accept) begin
         case (kind)
            KIND_STORE, KIND_FILTER: begin
               if (last) begin
                  col_ff <= '0;
                  row_ff <= row_ff + HEIGHT_REG_W'(1);
               end else begin
                  col_ff <= c_next;
               end
            end
            KIND_DRAIN: begin
               if (last) begin
                  col_ff   <= '0;
                  row_ff   <= '0;
                  drain_ff <= '0;
               end else begin
                  drain_ff <= c_next;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- line stores
   // the store of this row's parity gives the pixel above, the other one the right pixel
   assign wr_even      = store_px && (row_ff[0] == 1'b0);
   assign wr_odd       = store_px && (row_ff[0] == 1'b1);
   assign rd_addr_even = (row_ff[0] == 1'b0) ? c_sel : c_next;
   assign rd_addr_odd  = (row_ff[0] == 1'b1) ? c_sel : c_next;

   ipcf_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_ram_even (
      .clock   (clock),
      .wr_en   (wr_even),
      .wr_addr (c_sel),
      .wr_data (px_in),
      .rd_en   (accept),
      .rd_addr (rd_addr_even),
      .rd_data (rd_even)
   );

   ipcf_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_ram_odd (
      .clock   (clock),
      .wr_en   (wr_odd),
      .wr_addr (c_sel),
      .wr_data (px_in),
      .rd_en   (accept),
      .rd_addr (rd_addr_odd),
      .rd_data (rd_odd)
   );

   // ---------------------------------------------------------------- working stage
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_out     = (s1_kind_ff == KIND_FILTER) || (s1_kind_ff == KIND_DRAIN);
   assign s1_adv     = s1_valid_ff && (!s1_out || out_free);
   assign req_tready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff      <= kind;
         s1_par_ff       <= row_ff[0];
         s1_first_ff     <= c_sel == '0;
         s1_has_up_ff    <= row_ff >= HEIGHT_REG_W'(2);
         s1_has_right_ff <= !last;
         s1_last_ff      <= last;
         s1_px_ff        <= px_in;
      end
   end

   assign cur   = s1_first_ff ? first_px_ff : win_cur_ff;
   assign up    = s1_par_ff ? rd_odd : rd_even;
   assign right = s1_par_ff ? rd_even : rd_odd;

   always_comb begin
      best = '0;
      any  = 1'b0;
      peak = 1'b1;
      if (s1_has_up_ff) begin
         best = up;
         any  = 1'b1;
         if (!(cur > up)) peak = 1'b0;
      end
      if (s1_kind_ff == KIND_FILTER) begin
         if (!any || s1_px_ff > best) best = s1_px_ff;
         any = 1'b1;
         if (!(cur > s1_px_ff)) peak = 1'b0;
      end
      if (!s1_first_ff) begin
         if (!any || win_left_ff > best) best = win_left_ff;
         any = 1'b1;
         if (!(cur > win_left_ff)) peak = 1'b0;
      end
      if (s1_has_right_ff) begin
         if (!any || right > best) best = right;
         any = 1'b1;
         if (!(cur > right)) peak = 1'b0;
      end
      filtered = (any && peak) ? best : cur;
   end

   // sliding window over the row being filtered; column zero comes from first_px_ff
   always_ff @(posedge clock) begin
      if (s1_adv && s1_out) begin
         win_left_ff <= cur;
         win_cur_ff  <= right;
      end
      if (s1_adv && s1_first_ff
          && (s1_kind_ff == KIND_STORE || s1_kind_ff == KIND_FILTER)) begin
         first_px_ff <= s1_px_ff;
      end
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_out) begin
         rsp_pixel_ff <= PIXEL_FIELD_W'(filtered);
         rsp_last_ff  <= s1_last_ff;
         rsp_frame_ff <= (s1_kind_ff == KIND_DRAIN) && s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_frame_ff;

`ifndef NO_ASSERTIONS
   a_frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_ff |-> rsp_last_ff)
      else $error("frame end without row end");

   a_drain_needs_rows: assert property (@(posedge clock) disable iff (reset)
      drain_ff != '0 |-> row_ff != '0)
      else $error("drain count running with no rows held");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && kind == KIND_DRAIN && last
      |=> row_ff == '0 && col_ff == '0 && drain_ff == '0)
      else $error("counters not cleared at frame end");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_adv && s1_out))
      else $error("result appeared without a filtered transaction");

   a_no_write_when_drain: assert property (@(posedge clock) disable iff (reset)
      (wr_even || wr_odd) |-> !is_drain && !draining && !(wr_even && wr_odd))
      else $error("line store written outside pixel intake");
`endif

endmodule

`default_nettype wire
